// File: rtl/core/jtl_pkg.sv
// Shared widths, token kinds and record types for the JSON-like lexer.
`default_nettype none

package jtl_pkg;

   localparam int POS_BITS  = 24;
   localparam int LINE_BITS = 20;
   localparam int COL_BITS  = 16;
   localparam int BYTE_BITS = 8;
   localparam int KIND_BITS = 4;

   // token queue between lexer and output stage
   localparam int Q_DEPTH = 4;
   localparam int QPTR_W  = $clog2(Q_DEPTH);
   localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

   typedef enum logic [KIND_BITS-1:0] {
      K_EOF,
      K_LBRACE,
      K_RBRACE,
      K_LBRACK,
      K_RBRACK,
      K_COLON,
      K_COMMA,
      K_STRING,
      K_INT,
      K_IDENT,
      K_TRUE,
      K_FALSE,
      K_BADCHAR,
      K_UNTERM
   } kind_type;

   typedef struct packed {
      kind_type               kind;
      logic [POS_BITS-1:0]    start;
      logic [POS_BITS-1:0]    len;
      logic [LINE_BITS-1:0]   line;
      logic [COL_BITS-1:0]    col;
      logic [BYTE_BITS-1:0]   bad;
   } tok_type;

   // one queue entry: the tokens caused by one input item
   typedef struct packed {
      logic    two;
      tok_type t0;
      tok_type t1;
   } ent_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

endpackage

`default_nettype wire

// File: rtl/core/jtl_if.sv
// Valid/ready channel interfaces for source bytes and tokens.
`default_nettype none

interface jtl_req_if;
   import jtl_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [BYTE_BITS-1:0] byte_in;
   logic                 is_end;

   modport source (output valid, output byte_in, output is_end, input ready);
   modport sink   (input valid, input byte_in, input is_end, output ready);
endinterface

interface jtl_rsp_if;
   import jtl_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [KIND_BITS-1:0] kind;
   logic [POS_BITS-1:0]  start_offset;
   logic [POS_BITS-1:0]  token_length;
   logic [LINE_BITS-1:0] start_line;
   logic [COL_BITS-1:0]  start_column;
   logic [BYTE_BITS-1:0] bad_char;
   logic                 last;

   modport source (output valid, output kind, output start_offset, output token_length,
                   output start_line, output start_column, output bad_char,
                   output last, input ready);
   modport sink   (input valid, input kind, input start_offset, input token_length,
                   input start_line, input start_column, input bad_char,
                   input last, output ready);
endinterface

`default_nettype wire

// File: rtl/core/jtl_front.sv
// Lexer front end: scan state, position counters and token building.
`default_nettype none

module jtl_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   jtl_req_if.sink                   req_chan,
   input  wire jtl_pkg::q_stat_type  q_stat,
   output logic                      push,
   output jtl_pkg::ent_type          push_ent
);
   import jtl_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_STRING, S_ESC, S_NUMBER, S_IDENT, S_MINUS, S_SLASH, S_COMMENT
   } mode_type;

   localparam logic [BYTE_BITS-1:0] CH_LBRACE = 8'h7B;
   localparam logic [BYTE_BITS-1:0] CH_RBRACE = 8'h7D;
   localparam logic [BYTE_BITS-1:0] CH_LBRACK = 8'h5B;
   localparam logic [BYTE_BITS-1:0] CH_RBRACK = 8'h5D;
   localparam logic [BYTE_BITS-1:0] CH_COLON  = 8'h3A;
   localparam logic [BYTE_BITS-1:0] CH_COMMA  = 8'h2C;
   localparam logic [BYTE_BITS-1:0] CH_QUOTE  = 8'h22;
   localparam logic [BYTE_BITS-1:0] CH_BSLASH = 8'h5C;
   localparam logic [BYTE_BITS-1:0] CH_MINUS  = 8'h2D;
   localparam logic [BYTE_BITS-1:0] CH_SLASH  = 8'h2F;
   localparam logic [BYTE_BITS-1:0] CH_NL     = 8'h0A;
   localparam logic [BYTE_BITS-1:0] CH_CR     = 8'h0D;
   localparam logic [BYTE_BITS-1:0] CH_TAB    = 8'h09;
   localparam logic [BYTE_BITS-1:0] CH_SPACE  = 8'h20;

   // keyword tracker: 1..4 prefixes of true, 5..9 prefixes of false
   localparam logic [3:0] KW_NONE = 4'd0;
   localparam logic [3:0] KW_T    = 4'd1;
   localparam logic [3:0] KW_TR   = 4'd2;
   localparam logic [3:0] KW_TRU  = 4'd3;
   localparam logic [3:0] KW_TRUE = 4'd4;
   localparam logic [3:0] KW_F    = 4'd5;
   localparam logic [3:0] KW_FA   = 4'd6;
   localparam logic [3:0] KW_FAL  = 4'd7;
   localparam logic [3:0] KW_FALS = 4'd8;
   localparam logic [3:0] KW_FALSE = 4'd9;

   localparam logic [POS_BITS-1:0]  POS_MAX  = '1;
   localparam logic [LINE_BITS-1:0] LINE_MAX = '1;
   localparam logic [COL_BITS-1:0]  COL_MAX  = '1;
   localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);
   localparam logic [COL_BITS-1:0]  COL_ONE  = COL_BITS'(1);

   function automatic logic is_numeral(input logic [BYTE_BITS-1:0] b);
      return (b >= 8'h30) && (b <= 8'h39);
   endfunction

   function automatic logic is_alpha(input logic [BYTE_BITS-1:0] b);
      return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A)) ||
             (b == 8'h5F);
   endfunction

   function automatic logic [3:0] kw_next(input logic [3:0] p, input logic [BYTE_BITS-1:0] b);
      logic [3:0] r;
      r = KW_NONE;
      unique case (p)
         KW_T:    if (b == 8'h72) r = KW_TR;
         KW_TR:   if (b == 8'h75) r = KW_TRU;
         KW_TRU:  if (b == 8'h65) r = KW_TRUE;
         KW_F:    if (b == 8'h61) r = KW_FA;
         KW_FA:   if (b == 8'h6C) r = KW_FAL;
         KW_FAL:  if (b == 8'h73) r = KW_FALS;
         KW_FALS: if (b == 8'h65) r = KW_FALSE;
         default: r = KW_NONE;
      endcase
      return r;
   endfunction

   function automatic kind_type ident_kind(input logic [3:0] p);
      kind_type k;
      if (p == KW_TRUE)       k = K_TRUE;
      else if (p == KW_FALSE) k = K_FALSE;
      else                    k = K_IDENT;
      return k;
   endfunction

   function automatic tok_type mk_tok(input kind_type k, input logic [POS_BITS-1:0] s,
                                      input logic [POS_BITS-1:0] l,
                                      input logic [LINE_BITS-1:0] ln,
                                      input logic [COL_BITS-1:0] c,
                                      input logic [BYTE_BITS-1:0] bad);
      tok_type t;
      t.kind  = k;
      t.start = s;
      t.len   = l;
      t.line  = ln;
      t.col   = c;
      t.bad   = bad;
      return t;
   endfunction

   mode_type              mode_ff, mode_in;
   logic [3:0]            kw_ff, kw_in;
   logic [POS_BITS-1:0]   pos_ff, pos_in, pos_adv;
   logic [LINE_BITS-1:0]  line_ff, line_in, line_adv;
   logic [COL_BITS-1:0]   col_ff, col_in, col_adv;
   logic [POS_BITS-1:0]   ts_ff, ts_in;
   logic [LINE_BITS-1:0]  tl_ff, tl_in;
   logic [COL_BITS-1:0]   tc_ff, tc_in;

   logic                  accept;
   logic [BYTE_BITS-1:0]  b;
   logic                  run_idle;
   logic                  c_v, i_v;
   tok_type               c_tok, i_tok;
   kind_type              single_kind;
   logic                  single;

   assign b              = req_chan.byte_in;
   assign req_chan.ready = !q_stat.full;
   assign accept         = req_chan.valid && !q_stat.full;

   // position after this byte, saturating
   always_comb begin
      pos_adv  = (pos_ff == POS_MAX) ? pos_ff : pos_ff + POS_BITS'(1);
      line_adv = line_ff;
      col_adv  = col_ff;
      if (b == CH_NL) begin
         line_adv = (line_ff == LINE_MAX) ? line_ff : line_ff + LINE_BITS'(1);
         col_adv  = COL_ONE;
      end else if (col_ff != COL_MAX) begin
         col_adv = col_ff + COL_BITS'(1);
      end
   end

   always_comb begin
      single      = 1'b1;
      single_kind = K_LBRACE;
      unique case (b)
         CH_LBRACE: single_kind = K_LBRACE;
         CH_RBRACE: single_kind = K_RBRACE;
         CH_LBRACK: single_kind = K_LBRACK;
         CH_RBRACK: single_kind = K_RBRACK;
         CH_COLON:  single_kind = K_COLON;
         CH_COMMA:  single_kind = K_COMMA;
         default:   single = 1'b0;
      endcase
   end

   always_comb begin
      mode_in  = mode_ff;
      kw_in    = kw_ff;
      pos_in   = pos_adv;
      line_in  = line_adv;
      col_in   = col_adv;
      ts_in    = ts_ff;
      tl_in    = tl_ff;
      tc_in    = tc_ff;
      run_idle = 1'b0;
      c_v      = 1'b0;
      i_v      = 1'b0;
      c_tok    = mk_tok(K_EOF, ts_ff, '0, tl_ff, tc_ff, '0);
      i_tok    = mk_tok(K_EOF, pos_ff, '0, line_ff, col_ff, '0);

      if (req_chan.is_end) begin
         // flush held token, then end token, then back to reset state
         unique case (mode_ff)
            S_NUMBER: begin
               c_v   = 1'b1;
               c_tok = mk_tok(K_INT, ts_ff, pos_ff - ts_ff, tl_ff, tc_ff, '0);
            end
            S_IDENT: begin
               c_v   = 1'b1;
               c_tok = mk_tok(ident_kind(kw_ff), ts_ff, pos_ff - ts_ff, tl_ff, tc_ff, '0);
            end
            S_STRING, S_ESC: begin
               c_v   = 1'b1;
               c_tok = mk_tok(K_UNTERM, ts_ff, '0, tl_ff, tc_ff, '0);
            end
            S_MINUS: begin
               c_v   = 1'b1;
               c_tok = mk_tok(K_BADCHAR, ts_ff, '0, tl_ff, tc_ff, CH_MINUS);
            end
            S_SLASH: begin
               c_v   = 1'b1;
               c_tok = mk_tok(K_BADCHAR, ts_ff, '0, tl_ff, tc_ff, CH_SLASH);
            end
            default: c_v = 1'b0;
         endcase
         i_v     = 1'b1;
         mode_in = S_IDLE;
         kw_in   = KW_NONE;
         pos_in  = '0;
         line_in = LINE_ONE;
         col_in  = COL_ONE;
         ts_in   = '0;
         tl_in   = LINE_ONE;
         tc_in   = COL_ONE;
      end else begin
         unique case (mode_ff)
            S_STRING: begin
               if (b == CH_QUOTE) begin
                  c_v     = 1'b1;
                  c_tok   = mk_tok(K_STRING, ts_ff, pos_adv - ts_ff, tl_ff, tc_ff, '0);
                  mode_in = S_IDLE;
               end else if (b == CH_BSLASH) begin
                  mode_in = S_ESC;
               end else if (b == CH_NL) begin
                  c_v     = 1'b1;
                  c_tok   = mk_tok(K_UNTERM, ts_ff, '0, tl_ff, tc_ff, '0);
                  mode_in = S_IDLE;
               end
            end
            S_ESC: mode_in = S_STRING;
            S_NUMBER: begin
               if (!is_numeral(b)) begin
                  c_v      = 1'b1;
                  c_tok    = mk_tok(K_INT, ts_ff, pos_ff - ts_ff, tl_ff, tc_ff, '0);
                  run_idle = 1'b1;
               end
            end
            S_IDENT: begin
               if (is_alpha(b) || is_numeral(b)) begin
                  kw_in = kw_next(kw_ff, b);
               end else begin
                  c_v      = 1'b1;
                  c_tok    = mk_tok(ident_kind(kw_ff), ts_ff, pos_ff - ts_ff, tl_ff, tc_ff, '0);
                  kw_in    = KW_NONE;
                  run_idle = 1'b1;
               end
            end
            S_MINUS: begin
               if (is_numeral(b)) begin
                  mode_in = S_NUMBER;
               end else begin
                  c_v      = 1'b1;
                  c_tok    = mk_tok(K_BADCHAR, ts_ff, '0, tl_ff, tc_ff, CH_MINUS);
                  run_idle = 1'b1;
               end
            end
            S_SLASH: begin
               if (b == CH_SLASH) begin
                  mode_in = S_COMMENT;
               end else begin
                  c_v      = 1'b1;
                  c_tok    = mk_tok(K_BADCHAR, ts_ff, '0, tl_ff, tc_ff, CH_SLASH);
                  run_idle = 1'b1;
               end
            end
            S_COMMENT: if (b == CH_NL) mode_in = S_IDLE;
            S_IDLE:    run_idle = 1'b1;
            default:   mode_in = S_IDLE;
         endcase

         // lex the byte afresh, from the unadvanced position
         if (run_idle) begin
            mode_in = S_IDLE;
            if (!((b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || (b == CH_NL))) begin
               ts_in = pos_ff;
               tl_in = line_ff;
               tc_in = col_ff;
               if (single) begin
                  i_v   = 1'b1;
                  i_tok = mk_tok(single_kind, pos_ff, POS_BITS'(1), line_ff, col_ff, '0);
               end else if (b == CH_QUOTE) begin
                  mode_in = S_STRING;
               end else if (is_numeral(b)) begin
                  mode_in = S_NUMBER;
               end else if (b == CH_MINUS) begin
                  mode_in = S_MINUS;
               end else if (b == CH_SLASH) begin
                  mode_in = S_SLASH;
               end else if (is_alpha(b)) begin
                  mode_in = S_IDENT;
                  kw_in   = (b == 8'h74) ? KW_T : ((b == 8'h66) ? KW_F : KW_NONE);
               end else begin
                  i_v   = 1'b1;
                  i_tok = mk_tok(K_BADCHAR, pos_ff, '0, line_ff, col_ff, b);
               end
            end
         end
      end
   end

   assign push         = accept && (c_v || i_v);
   assign push_ent.two = c_v && i_v;
   assign push_ent.t0  = c_v ? c_tok : i_tok;
   assign push_ent.t1  = i_tok;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= S_IDLE;
         kw_ff   <= KW_NONE;
         pos_ff  <= '0;
         line_ff <= LINE_ONE;
         col_ff  <= COL_ONE;
         ts_ff   <= '0;
         tl_ff   <= LINE_ONE;
         tc_ff   <= COL_ONE;
      end else if (accept) begin
         mode_ff <= mode_in;
         kw_ff   <= kw_in;
         pos_ff  <= pos_in;
         line_ff <= line_in;
         col_ff  <= col_in;
         ts_ff   <= ts_in;
         tl_ff   <= tl_in;
         tc_ff   <= tc_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/jtl_queue.sv
// Small FIFO of token entries between lexer front end and output stage.
`default_nettype none

module jtl_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire jtl_pkg::ent_type push_ent,
   input  wire logic             pop,
   output jtl_pkg::ent_type      pop_ent,
   output jtl_pkg::q_stat_type   q_stat
);
   import jtl_pkg::*;

   localparam logic [QPTR_W-1:0] PTR_LAST = QPTR_W'(Q_DEPTH - 1);
   localparam logic [QCNT_W-1:0] CNT_FULL = QCNT_W'(Q_DEPTH);

   ent_type              mem [Q_DEPTH];
   logic [QPTR_W-1:0]    wr_ff, rd_ff;
   logic [QCNT_W-1:0]    cnt_ff;
   logic                 do_push, do_pop;

   assign q_stat.full  = (cnt_ff == CNT_FULL);
   assign q_stat.empty = (cnt_ff == '0);
   assign do_push      = push && !q_stat.full;
   assign do_pop       = pop && !q_stat.empty;
   assign pop_ent      = mem[rd_ff];

   always_ff @(posedge clock) begin
      if (do_push) mem[wr_ff] <= push_ent;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) wr_ff <= (wr_ff == PTR_LAST) ? '0 : wr_ff + QPTR_W'(1);
         if (do_pop)  rd_ff <= (rd_ff == PTR_LAST) ? '0 : rd_ff + QPTR_W'(1);
         if (do_push && !do_pop)      cnt_ff <= cnt_ff + QCNT_W'(1);
         else if (do_pop && !do_push) cnt_ff <= cnt_ff - QCNT_W'(1);
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/jtl_back.sv
// Output stage: takes one queue entry and sends its one or two tokens.
`default_nettype none

module jtl_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire jtl_pkg::q_stat_type  q_stat,
   input  wire jtl_pkg::ent_type     pop_ent,
   output logic                      pop,
   jtl_rsp_if.source                 rsp_chan
);
   import jtl_pkg::*;

   logic     hold_ff;
   logic     idx_ff;
   ent_type  ent_ff;
   tok_type  cur;
   logic     fin;
   logic     sent;

   assign cur  = idx_ff ? ent_ff.t1 : ent_ff.t0;
   assign sent = hold_ff && rsp_chan.ready;
   assign fin  = sent && (idx_ff || !ent_ff.two);
   assign pop  = (!hold_ff || fin) && !q_stat.empty;

   assign rsp_chan.valid        = hold_ff;
   assign rsp_chan.kind         = cur.kind;
   assign rsp_chan.start_offset = cur.start;
   assign rsp_chan.token_length = cur.len;
   assign rsp_chan.start_line   = cur.line;
   assign rsp_chan.start_column = cur.col;
   assign rsp_chan.bad_char     = cur.bad;
   assign rsp_chan.last         = idx_ff || !ent_ff.two;

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff <= 1'b0;
         idx_ff  <= 1'b0;
      end else if (pop) begin
         hold_ff <= 1'b1;
         idx_ff  <= 1'b0;
      end else if (fin) begin
         hold_ff <= 1'b0;
         idx_ff  <= 1'b0;
      end else if (sent) begin
         idx_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) ent_ff <= pop_ent;
   end

endmodule

`default_nettype wire

// File: rtl/core/json_like_token_lexer_core.sv
// Top level of the streaming lexer for a JSON-like language.
//
//   channel   dir  handshake               item
//   req_chan  in   valid/ready             byte_in, is_end (one source byte or end mark)
//   rsp_chan  out  valid/ready             kind, start_offset, token_length,
//                                          start_line, start_column, bad_char, last
//
// One byte is accepted per cycle while the token queue is not full; the lexer state
// and counters update in that cycle. A byte's tokens are written into the queue and
// then loaded into the output stage register before they are offered on rsp_chan.
// A byte yields zero, one or two tokens; the output stage sends one token per cycle
// while rsp_chan.ready is high; a two-token byte holds it until both tokens are sent.
// A four-entry token queue sits between lexer and output stage; req_chan.ready drops
// only when that queue is full, so output stalls reach the input after five
// token-bearing bytes (four queued, one held in the output stage).
// Reset is synchronous, active high; it clears the scan state, counters and queue.
`default_nettype none

module json_like_token_lexer_core (
   input  wire logic   clock,
   input  wire logic   reset,
   jtl_req_if.sink     req_chan,
   jtl_rsp_if.source   rsp_chan
);
   import jtl_pkg::*;

   q_stat_type  q_stat;    // queue full / empty
   ent_type     push_ent;  // tokens of the byte just accepted
   ent_type     pop_ent;   // head of queue
   logic        push;
   logic        pop;

   // front end: scan state machine, one byte per accepted item
   jtl_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_stat   (q_stat),
      .push     (push),
      .push_ent (push_ent)
   );

   // decoupling queue, one entry per byte that produced tokens
   jtl_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_ent (push_ent),
      .pop      (pop),
      .pop_ent  (pop_ent),
      .q_stat   (q_stat)
   );

   // back end: registered output, splits two-token entries
   jtl_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_stat   (q_stat),
      .pop_ent  (pop_ent),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire
